>>> sv/uct_pkg.sv
// package for the utf-8 code point table transliterator
// holds payload types, controller/datapath command and status structs, and constants
// no dependencies
package uct_pkg;

   // default sizes handed to the top level parameters
   localparam int TABLE_DEPTH_DEF = 16384;
   localparam int TEXT_BYTES_DEF  = 7;

   // fixed field widths
   localparam int CODE_W       = 21;
   localparam int TEXT_FIELD_W = 56;
   localparam int ENTRY_IDX_W  = 14;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 15;
   localparam int ENTRIES_W    = 15;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRIES_IN_USE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_FIRST    = 1'd1;

   // request commands
   localparam logic CMD_TEXT  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // utf-8 byte classes and masks
   localparam logic [7:0] ASCII_LIMIT = 8'h80;
   localparam logic [7:0] LEAD2_BASE  = 8'hC0;
   localparam logic [7:0] LEAD3_BASE  = 8'hE0;
   localparam logic [7:0] LEAD4_BASE  = 8'hF0;
   localparam logic [7:0] LEAD_LIMIT  = 8'hF8;
   localparam logic [7:0] LEAD2_MASK  = 8'h1F;
   localparam logic [7:0] LEAD3_MASK  = 8'h0F;
   localparam logic [7:0] LEAD4_MASK  = 8'h07;
   localparam logic [7:0] CONT_MASK   = 8'h3F;
   localparam logic [7:0] CASE_OFFSET = 8'd32;

   typedef struct packed {
      logic                    cmd;
      logic [7:0]              text_byte;
      logic                    end_of_text;
      logic [ENTRY_IDX_W-1:0]  entry_index;
      logic [CODE_W-1:0]       entry_code;
      logic [TEXT_FIELD_W-1:0] entry_text;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic take_req;
      logic fetch;
      logic compare;
      logic emit_byte;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic search_start;
      logic hit;
      logic range_left;
      logic byte_zero;
      logic last_byte;
      logic slot_free;
   } dp_status_type;

endpackage

>>> sv/uct_ctrl.sv
// controller state machine for the transliterator
// sequences request intake, table probes and byte emission; uses uct_pkg
module uct_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  uct_pkg::dp_status_type dp_status,
   output uct_pkg::dp_cmd_type    dp_cmd
);
   import uct_pkg::*;

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_FETCH   = 2'd1;
   localparam logic [1:0] ST_COMPARE = 2'd2;
   localparam logic [1:0] ST_EMIT    = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // handshake and commands
   assign req_ready        = (state_ff == ST_IDLE) && dp_status.slot_free;
   assign dp_cmd.take_req  = req_valid && req_ready;
   assign dp_cmd.fetch     = (state_ff == ST_FETCH);
   assign dp_cmd.compare   = (state_ff == ST_COMPARE);
   assign dp_cmd.emit_byte = (state_ff == ST_EMIT) && !dp_status.byte_zero
                             && dp_status.slot_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (dp_cmd.take_req && dp_status.search_start) state_in = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            if (dp_status.hit)             state_in = ST_EMIT;
            else if (dp_status.range_left) state_in = ST_FETCH;
            else                           state_in = ST_IDLE;
         end
         ST_EMIT: begin
            // an entry whose next byte is zero ends the run
            if (dp_status.byte_zero) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (dp_cmd.emit_byte && dp_status.last_byte) state_in = ST_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sv/uct_datapath.sv
// datapath for the transliterator: utf-8 decoder, code/text table memories,
// binary search bounds, emit shifter and output register; uses uct_pkg
module uct_datapath #(
   parameter int TABLE_DEPTH = uct_pkg::TABLE_DEPTH_DEF,
   parameter int TEXT_BYTES  = uct_pkg::TEXT_BYTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [uct_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [uct_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  uct_pkg::req_payload_type            req_payload,
   input  logic                                rsp_ready,
   input  uct_pkg::dp_cmd_type                 dp_cmd,
   output uct_pkg::dp_status_type              dp_status,
   output logic                                rsp_valid,
   output uct_pkg::rsp_payload_type            rsp_payload
);
   import uct_pkg::*;

   localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int TEXT_W = 8 * TEXT_BYTES;
   localparam int EMIT_W = TEXT_W + 8;

   // configuration
   logic [ENTRIES_W-1:0] entries_ff;
   logic                 upper_ff;

   // decoder state
   logic [CODE_W-1:0] partial_ff, partial_in;
   logic [1:0]        pending_ff, pending_in;
   logic              passthru, complete;
   logic [7:0]        cont_bits;
   logic [CODE_W-1:0] code_done;

   // search state
   logic [CODE_W-1:0] code_ff;
   logic [CNT_W-1:0]  lo_ff, hi_ff, mid_ff;
   logic [CNT_W-1:0]  mid_in, mid_next, hi_start;
   logic [CODE_W-1:0] key_ff;
   logic [TEXT_W-1:0] rd_text_ff;
   logic              less;

   // emission and output
   logic [EMIT_W-1:0]  emit_ff;
   logic               first_ff;
   logic [7:0]         emit_byte;
   logic               rsp_valid_ff;
   rsp_payload_type    rsp_payload_ff;
   logic               is_text, is_write, pass_load;

   // table memories
   logic [CODE_W-1:0] code_mem [TABLE_DEPTH];
   logic [TEXT_W-1:0] text_mem [TABLE_DEPTH];
   logic [31:0]       idx_ext;
   logic              idx_ok;

   assign is_text  = dp_cmd.take_req && (req_payload.cmd == CMD_TEXT);
   assign is_write = dp_cmd.take_req && (req_payload.cmd == CMD_WRITE);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= '0;
         upper_ff   <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ENTRIES_IN_USE: entries_ff <= csr_wdata[ENTRIES_W-1:0];
            CSR_UPPER_FIRST:    upper_ff   <= csr_wdata[0];
            default:            ;
         endcase
      end
   end

   // utf-8 decode of one text byte
   assign cont_bits = req_payload.text_byte & CONT_MASK;
   assign code_done = {partial_ff[CODE_W-7:0], cont_bits[5:0]};

   always_comb begin
      partial_in = partial_ff;
      pending_in = pending_ff;
      passthru   = 1'b0;
      complete   = 1'b0;
      if (pending_ff == 2'd0) begin
         case (req_payload.text_byte) inside
            [8'h00 : ASCII_LIMIT - 8'd1]: begin
               passthru = 1'b1;
            end
            [LEAD2_BASE : LEAD3_BASE - 8'd1]: begin
               partial_in = CODE_W'(req_payload.text_byte & LEAD2_MASK);
               pending_in = 2'd1;
            end
            [LEAD3_BASE : LEAD4_BASE - 8'd1]: begin
               partial_in = CODE_W'(req_payload.text_byte & LEAD3_MASK);
               pending_in = 2'd2;
            end
            [LEAD4_BASE : LEAD_LIMIT - 8'd1]: begin
               partial_in = CODE_W'(req_payload.text_byte & LEAD4_MASK);
               pending_in = 2'd3;
            end
            default: begin
               // stray continuation or invalid lead: dropped
            end
         endcase
      end else begin
         pending_in = pending_ff - 2'd1;
         if (pending_ff == 2'd1) begin
            complete   = 1'b1;
            partial_in = '0;
         end else begin
            partial_in = code_done;
         end
      end
      // end of text drops an unfinished sequence
      if (req_payload.end_of_text) begin
         partial_in = '0;
         pending_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         pending_ff <= 2'd0;
      end else if (is_text) begin
         partial_ff <= partial_in;
         pending_ff <= pending_in;
      end
   end

   // search bounds, upper bound saturated to the table depth
   assign hi_start = (32'(entries_ff) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                     : CNT_W'(entries_ff);
   assign mid_in   = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign mid_next = mid_ff + CNT_W'(1);
   assign less     = code_ff < key_ff;

   always_ff @(posedge clock) begin
      if (is_text) begin
         code_ff <= code_done;
         lo_ff   <= '0;
         hi_ff   <= hi_start;
      end
      if (dp_cmd.fetch) begin
         mid_ff <= mid_in;
      end
      if (dp_cmd.compare && !dp_status.hit) begin
         if (less) hi_ff <= mid_ff;
         else      lo_ff <= mid_next;
      end
   end

   // table write port
   assign idx_ext = 32'(req_payload.entry_index);
   assign idx_ok  = idx_ext < TABLE_DEPTH;

   always_ff @(posedge clock) begin
      if (is_write && idx_ok) begin
         code_mem[idx_ext[IDX_W-1:0]] <= req_payload.entry_code;
         text_mem[idx_ext[IDX_W-1:0]] <= req_payload.entry_text[TEXT_W-1:0];
      end
   end

   // table read port, registered
   always_ff @(posedge clock) begin
      if (dp_cmd.fetch) begin
         key_ff     <= code_mem[mid_in[IDX_W-1:0]];
         rd_text_ff <= text_mem[mid_in[IDX_W-1:0]];
      end
   end

   // emit shifter, a zero byte above the text ends every run
   always_ff @(posedge clock) begin
      if (dp_cmd.compare && dp_status.hit) begin
         emit_ff  <= {8'h00, rd_text_ff};
         first_ff <= 1'b1;
      end else if (dp_cmd.emit_byte) begin
         emit_ff  <= emit_ff >> 8;
         first_ff <= 1'b0;
      end
   end

   assign emit_byte = (first_ff && upper_ff) ? (emit_ff[7:0] - CASE_OFFSET) : emit_ff[7:0];

   // output register
   assign pass_load = is_text && passthru;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pass_load || dp_cmd.emit_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pass_load) begin
         rsp_payload_ff.out_byte    <= req_payload.text_byte;
         rsp_payload_ff.last_of_run <= 1'b1;
      end else if (dp_cmd.emit_byte) begin
         rsp_payload_ff.out_byte    <= emit_byte;
         rsp_payload_ff.last_of_run <= (emit_ff[15:8] == 8'h00);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // status for the controller
   assign dp_status.search_start = (req_payload.cmd == CMD_TEXT) && complete
                                   && (hi_start != '0);
   assign dp_status.hit          = (code_ff == key_ff);
   assign dp_status.range_left   = less ? (lo_ff < mid_ff) : (mid_next < hi_ff);
   assign dp_status.byte_zero    = (emit_ff[7:0] == 8'h00);
   assign dp_status.last_byte    = (emit_ff[15:8] == 8'h00);
   assign dp_status.slot_free    = !rsp_valid_ff || rsp_ready;

endmodule

>>> sv/utf8_codepoint_table_transliterator.sv
// top level of the utf-8 code point table transliterator
// joins uct_ctrl and uct_datapath; uses uct_pkg
//
//   channel   dir   handshake              payload
//   req       in    req_valid/req_ready    req_payload (req_payload_type)
//   rsp       out   rsp_valid/rsp_ready    rsp_payload (rsp_payload_type)
//   csr       in    csr_we                 csr_index, csr_wdata
//
// ascii bytes, table writes and bytes inside a sequence leave the controller idle.
// a completed code point starts a search; each probe is a registered table read,
// then a compare, at most ceil(log2(entries+1)) probes; a hit then emits one byte
// per cycle unless rsp stalls, none for empty text; a miss goes straight back to idle.
// the tables have undefined contents after reset; no clearing pass is run.
// a stalled rsp side holds the byte in the output register and stops req intake.
module utf8_codepoint_table_transliterator #(
   parameter int TABLE_DEPTH = uct_pkg::TABLE_DEPTH_DEF,
   parameter int TEXT_BYTES  = uct_pkg::TEXT_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [uct_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [uct_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  uct_pkg::req_payload_type       req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output uct_pkg::rsp_payload_type       rsp_payload
);
   import uct_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // controller
   uct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   // datapath
   uct_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .TEXT_BYTES  (TEXT_BYTES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .rsp_ready   (rsp_ready),
      .dp_cmd      (dp_cmd),
      .dp_status   (dp_status),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

`ifndef NO_ASSERTIONS
   // a table probe always compares right after its read
   assert property (@(posedge clock) disable iff (reset) dp_cmd.fetch |=> dp_cmd.compare)
      else $error("probe read not followed by compare");

   // an emitted byte never overwrites a waiting one
   assert property (@(posedge clock) disable iff (reset)
      dp_cmd.emit_byte |-> dp_status.slot_free)
      else $error("emit into occupied output register");

   // no request intake while a search or emission runs
   assert property (@(posedge clock) disable iff (reset)
      !(dp_cmd.take_req && (dp_cmd.fetch || dp_cmd.compare || dp_cmd.emit_byte)))
      else $error("request taken during search or emission");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");
`endif

endmodule

>>> test/utf8_codepoint_table_transliterator_tb.sv
// self-checking testbench for utf8_codepoint_table_transliterator
// drives text bytes and table writes, predicts the emitted bytes, checks every result
// depends on uct_pkg and the rtl of the block only
`timescale 1ns / 100ps

module utf8_codepoint_table_transliterator_tb;
   import uct_pkg::*;

   localparam int DEPTH = TABLE_DEPTH_DEF;
   localparam int TEXT_LEN = TEXT_BYTES_DEF;
   localparam logic [CODE_W-1:0] CODE_MAX = '1;
   // settle time covers the longest search, 15 probes and 7 bytes, with margin
   localparam int SETTLE_CYCLES = 64;
   localparam int HOLD_CYCLES = 400;
   // about 450 requests stay well within this limit even at the worst stalls
   localparam int LIMIT = 1_000_000;

   typedef struct {
      bit                    is_csr;
      logic [CSR_IDX_W-1:0]  csr_idx;
      int                    csr_val;
      req_payload_type       req;
      bit                    typed;
      int                    typed_n;
      logic [7:0]            typed_byte;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_payload_type       rsp_payload;

   // predictor state: table copy, decoder state, register copies
   logic [CODE_W-1:0]       table_code [DEPTH];
   logic [TEXT_FIELD_W-1:0] table_text [DEPTH];
   logic [CODE_W-1:0]       seq_code = '0;
   int                      seq_left = 0;
   int                      entries_cfg = 0;
   bit                      upper_cfg = 1'b0;
   rsp_payload_type         step_bytes[$];
   rsp_payload_type         expected_bytes[$];
   rsp_payload_type         want;
   stim_row_type            directed_rows[$];

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;
   int mismatches = 0;
   int results_checked = 0;
   int requests_sent = 0;
   int text_items = 0;
   int cycle_count = 0;

   utf8_codepoint_table_transliterator dut (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #10 clock = ~clock;

   task automatic report_mismatch(input string what, input int got, input int want_v);
      mismatches++;
      $display("tb: mismatch, %s: got %0h, want %0h, after %0d results",
               what, got, want_v, results_checked);
   endtask

   // bytes emitted for one request; updates the table and decoder copies
   function automatic void transliterate(input req_payload_type p);
      int lo;
      int hi;
      int mid;
      int k;
      bit found;
      bit stop;
      logic [7:0] b;
      rsp_payload_type r;
      step_bytes.delete();
      if (p.cmd == CMD_WRITE) begin
         table_code[p.entry_index] = p.entry_code;
         table_text[p.entry_index] = p.entry_text;
      end else begin
         if (seq_left == 0) begin
            if (p.text_byte < ASCII_LIMIT) begin
               r.out_byte = p.text_byte;
               r.last_of_run = 1'b1;
               step_bytes = {step_bytes, r};
            end else if (p.text_byte >= LEAD2_BASE && p.text_byte < LEAD3_BASE) begin
               seq_code = CODE_W'(p.text_byte & LEAD2_MASK);
               seq_left = 1;
            end else if (p.text_byte >= LEAD3_BASE && p.text_byte < LEAD4_BASE) begin
               seq_code = CODE_W'(p.text_byte & LEAD3_MASK);
               seq_left = 2;
            end else if (p.text_byte >= LEAD4_BASE && p.text_byte < LEAD_LIMIT) begin
               seq_code = CODE_W'(p.text_byte & LEAD4_MASK);
               seq_left = 3;
            end
         end else begin
            // any byte counts as a continuation, low six bits only
            seq_code = {seq_code[CODE_W-7:0], 6'(p.text_byte & CONT_MASK)};
            seq_left--;
            if (seq_left == 0) begin
               lo = 0;
               hi = (entries_cfg > DEPTH) ? DEPTH : entries_cfg;
               found = 1'b0;
               mid = 0;
               while (lo < hi && !found) begin
                  mid = lo + (hi - lo) / 2;
                  if (seq_code == table_code[mid]) found = 1'b1;
                  else if (seq_code < table_code[mid]) hi = mid;
                  else lo = mid + 1;
               end
               if (found) begin
                  stop = 1'b0;
                  for (k = 0; k < TEXT_LEN; k++) begin
                     b = table_text[mid][8*k +: 8];
                     if (b == 8'h00) stop = 1'b1;
                     if (!stop) begin
                        if (k == 0 && upper_cfg) b = b - CASE_OFFSET;
                        r.out_byte = b;
                        r.last_of_run = 1'b0;
                        step_bytes = {step_bytes, r};
                     end
                  end
                  if (step_bytes.size() > 0) step_bytes[step_bytes.size()-1].last_of_run = 1'b1;
               end
               seq_code = '0;
            end
         end
         // end of text drops an unfinished sequence
         if (p.end_of_text) begin
            seq_code = '0;
            seq_left = 0;
         end
      end
   endfunction

   // request builders; fields the command ignores are random
   function automatic req_payload_type text_req(input logic [7:0] b, input bit eot);
      req_payload_type p;
      p.entry_index = ENTRY_IDX_W'($urandom);
      p.entry_code = CODE_W'($urandom);
      p.entry_text = TEXT_FIELD_W'({$urandom, $urandom});
      p.cmd = CMD_TEXT;
      p.text_byte = b;
      p.end_of_text = eot;
      return p;
   endfunction

   function automatic req_payload_type write_req(input logic [ENTRY_IDX_W-1:0] idx,
                                                  input logic [CODE_W-1:0] code,
                                                  input logic [TEXT_FIELD_W-1:0] txt);
      req_payload_type p;
      p.cmd = CMD_WRITE;
      p.text_byte = 8'($urandom);
      p.end_of_text = 1'($urandom);
      p.entry_index = idx;
      p.entry_code = code;
      p.entry_text = txt;
      return p;
   endfunction

   // directed table rows
   function automatic stim_row_type row_text(input logic [7:0] b, input bit eot);
      stim_row_type row;
      row = '{default: '0};
      row.req = text_req(b, eot);
      return row;
   endfunction

   function automatic stim_row_type row_typed(input logic [7:0] b, input int n,
                                              input logic [7:0] outb);
      stim_row_type row;
      row = row_text(b, 1'b0);
      row.typed = 1'b1;
      row.typed_n = n;
      row.typed_byte = outb;
      return row;
   endfunction

   function automatic stim_row_type row_write(input int idx, input int code,
                                              input logic [TEXT_FIELD_W-1:0] txt);
      stim_row_type row;
      row = '{default: '0};
      row.req = write_req(ENTRY_IDX_W'(idx), CODE_W'(code), txt);
      row.typed = 1'b1;
      return row;
   endfunction

   function automatic stim_row_type row_csr(input logic [CSR_IDX_W-1:0] idx, input int val);
      stim_row_type row;
      row = '{default: '0};
      row.is_csr = 1'b1;
      row.csr_idx = idx;
      row.csr_val = val;
      return row;
   endfunction

   function automatic int code_len(input logic [CODE_W-1:0] code);
      if (code < 'h800) return 2;
      if (code < 'h10000) return 3;
      return 4;
   endfunction

   // sender: random gaps, then hold valid until accepted
   task automatic deliver(input req_payload_type p);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
   endtask

   task automatic send_and_predict(input req_payload_type p);
      deliver(p);
      transliterate(p);
      foreach (step_bytes[i]) expected_bytes = {expected_bytes, step_bytes[i]};
   endtask

   task automatic send_byte(input logic [7:0] b, input bit eot);
      send_and_predict(text_req(b, eot));
      text_items++;
   endtask

   // utf-8 encoding of code in len bytes, sometimes with odd continuation tops
   task automatic send_code(input logic [CODE_W-1:0] code, input int len);
      logic [7:0] b;
      int i;
      case (len)
         2: b = LEAD2_BASE | 8'(code[10:6]);
         3: b = LEAD3_BASE | 8'(code[15:12]);
         default: b = LEAD4_BASE | 8'(code[20:18]);
      endcase
      send_byte(b, 1'b0);
      for (i = len - 2; i >= 0; i--) begin
         b = ASCII_LIMIT | 8'(code[6*i +: 6]);
         if ($urandom_range(9) == 0) b[7:6] = 2'($urandom);
         send_byte(b, i == 0 && $urandom_range(9) == 0);
      end
   endtask

   // idle means no result outstanding and any silent search finished
   task automatic wait_idle();
      @(negedge clock) req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int val);
      wait_idle();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(val);
      @(negedge clock) csr_we <= 1'b0;
      if (idx == CSR_ENTRIES_IN_USE) entries_cfg = val;
      else upper_cfg = val[0];
   endtask

   // fill slots 0..n-1, keys ascending with duplicates or scrambled
   task automatic load_table(input int n, input bit scrambled, input int span);
      int step_max;
      int code;
      int len;
      int i;
      int k;
      logic [TEXT_FIELD_W-1:0] txt;
      step_max = span / n;
      if (step_max < 1) step_max = 1;
      code = $urandom_range(step_max);
      for (i = 0; i < n; i++) begin
         if (scrambled) begin
            if (i == 0 || $urandom_range(7) != 0) code = $urandom_range(CODE_MAX);
         end else if (i > 0 && $urandom_range(7) != 0) begin
            code = code + $urandom_range(step_max, 1);
         end
         if (code > CODE_MAX) code = CODE_MAX;
         len = $urandom_range(TEXT_LEN);
         txt = TEXT_FIELD_W'({$urandom, $urandom});
         for (k = 0; k < len; k++)
            if (txt[8*k +: 8] == 8'h00) txt[8*k +: 8] = 8'h01;
         if (len < TEXT_LEN) txt[8*len +: 8] = 8'h00;
         send_and_predict(write_req(ENTRY_IDX_W'(i), CODE_W'(code), txt));
      end
   endtask

   // mostly well-formed sequences aimed at table keys, plus noise
   task automatic random_text(input int count);
      int goal;
      int pick;
      int span;
      int len;
      int frag;
      int i;
      logic [CODE_W-1:0] code;
      logic [7:0] lead;
      goal = text_items + count;
      while (text_items < goal) begin
         pick = $urandom_range(99);
         span = (entries_cfg > DEPTH) ? DEPTH : entries_cfg;
         if (pick < 55) begin
            code = (span > 0) ? table_code[$urandom_range(span - 1)] : CODE_W'($urandom);
            send_code(code, code_len(code));
         end else if (pick < 70) begin
            code = CODE_W'($urandom);
            len = $urandom_range(4, code_len(code));
            send_code(code, len);
         end else if (pick < 85) begin
            send_byte(8'($urandom_range(ASCII_LIMIT - 1)), $urandom_range(9) == 0);
         end else if (pick < 92) begin
            if ($urandom_range(1))
               send_byte(8'($urandom_range(LEAD2_BASE - 1, ASCII_LIMIT)), $urandom_range(9) == 0);
            else
               send_byte(8'($urandom_range(8'hFF, LEAD_LIMIT)), $urandom_range(9) == 0);
         end else if (pick < 97) begin
            // sequence cut short by end of text
            len = $urandom_range(4, 2);
            case (len)
               2: lead = 8'($urandom_range(LEAD3_BASE - 1, LEAD2_BASE));
               3: lead = 8'($urandom_range(LEAD4_BASE - 1, LEAD3_BASE));
               default: lead = 8'($urandom_range(LEAD_LIMIT - 1, LEAD4_BASE));
            endcase
            frag = $urandom_range(len - 2);
            send_byte(lead, frag == 0);
            for (i = 1; i <= frag; i++)
               send_byte(ASCII_LIMIT | 8'($urandom_range(CONT_MASK)), i == frag);
         end else begin
            // table write, in use or anywhere
            if (span > 0 && $urandom_range(1))
               i = $urandom_range(span - 1);
            else
               i = $urandom_range(DEPTH - 1);
            send_and_predict(write_req(ENTRY_IDX_W'(i), CODE_W'($urandom),
                                       TEXT_FIELD_W'({$urandom, $urandom})));
         end
      end
   endtask

   task automatic run_setting(input int entries, input bit upper, input int count,
                              input bit hold);
      write_csr(CSR_ENTRIES_IN_USE, entries);
      write_csr(CSR_UPPER_FIRST, upper);
      if (hold) hold_requests++;
      random_text(count);
   endtask

   // receiver: random ready, long hold-off on request
   always @(negedge clock) begin
      if (hold_requests != holds_served) begin
         holds_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // result checker against the oldest expected byte
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch("result with nothing expected", int'(rsp_payload.out_byte), 0);
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_payload.out_byte !== want.out_byte)
               report_mismatch("out_byte", int'(rsp_payload.out_byte),
                               int'(want.out_byte));
            if (rsp_payload.last_of_run !== want.last_of_run)
               report_mismatch("last_of_run", int'(rsp_payload.last_of_run),
                               int'(want.last_of_run));
            results_checked++;
         end
      end
   end

   // run limit
   initial begin
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      tx_idle_pct = 13;
      rx_idle_pct = 80;

      // ascii extremes, stray continuation, invalid lead
      directed_rows = {directed_rows, row_typed(8'h00, 1, 8'h00)};
      directed_rows = {directed_rows, row_typed(8'h7F, 1, 8'h7F)};
      directed_rows = {directed_rows, row_typed(8'h80, 0, 8'h00)};
      directed_rows = {directed_rows, row_typed(8'hF8, 0, 8'h00)};
      // small sorted table: key zero, two- three- four-byte keys, largest key
      directed_rows = {directed_rows, row_write(0, 'h0, 56'h10)};
      directed_rows = {directed_rows, row_write(1, 'hE9, 56'h65)};
      directed_rows = {directed_rows, row_write(2, 'h20AC, 56'h52_55_45)};
      directed_rows = {directed_rows, row_write(3, 'h1F600, 56'hFF_FFFF_FFFF_FFFF)};
      directed_rows = {directed_rows, row_write(4, 'h1FFFFF, 56'h4100)};
      directed_rows = {directed_rows, row_csr(CSR_ENTRIES_IN_USE, 5)};
      directed_rows = {directed_rows, row_csr(CSR_UPPER_FIRST, 0)};
      // overlong key zero, euro sign, full seven-byte text
      directed_rows = {directed_rows, row_text(8'hC0, 1'b0)};
      directed_rows = {directed_rows, row_text(8'h80, 1'b0)};
      directed_rows = {directed_rows, row_text(8'hE2, 1'b0)};
      directed_rows = {directed_rows, row_text(8'h82, 1'b0)};
      directed_rows = {directed_rows, row_text(8'hAC, 1'b0)};
      directed_rows = {directed_rows, row_text(8'hF0, 1'b0)};
      directed_rows = {directed_rows, row_text(8'h9F, 1'b0)};
      directed_rows = {directed_rows, row_text(8'h98, 1'b0)};
      directed_rows = {directed_rows, row_text(8'h80, 1'b0)};
      // largest key: a hit whose text starts with zero
      directed_rows = {directed_rows, row_text(8'hF7, 1'b0)};
      directed_rows = {directed_rows, row_text(8'hBF, 1'b0)};
      directed_rows = {directed_rows, row_text(8'hBF, 1'b0)};
      directed_rows = {directed_rows, row_text(8'hBF, 1'b0)};
      // table write inside a sequence, continuation not of form 10xxxxxx
      directed_rows = {directed_rows, row_text(8'hC3, 1'b0)};
      directed_rows = {directed_rows, row_write(5, 'h100, 56'h5A)};
      directed_rows = {directed_rows, row_text(8'h29, 1'b0)};
      // end of text in the middle of a sequence
      directed_rows = {directed_rows, row_text(8'hE2, 1'b0)};
      directed_rows = {directed_rows, row_text(8'h82, 1'b1)};
      // upper-first with wrap below zero
      directed_rows = {directed_rows, row_csr(CSR_UPPER_FIRST, 1)};
      directed_rows = {directed_rows, row_text(8'hC0, 1'b0)};
      directed_rows = {directed_rows, row_text(8'h80, 1'b0)};

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            write_csr(directed_rows[i].csr_idx, directed_rows[i].csr_val);
         end else begin
            deliver(directed_rows[i].req);
            transliterate(directed_rows[i].req);
            if (!directed_rows[i].typed) begin
               foreach (step_bytes[j]) expected_bytes = {expected_bytes, step_bytes[j]};
            end else if (directed_rows[i].typed_n != 0) begin
               want.out_byte = directed_rows[i].typed_byte;
               want.last_of_run = 1'b1;
               expected_bytes = {expected_bytes, want};
            end
         end
      end

      // slow receiver, including a long hold-off that backs up the input
      load_table(32, 1'b0, 'h10000);
      run_setting(32, 1'b0, 50, 1'b1);
      run_setting(1, 1'b1, 50, 1'b0);

      // slow sender, scrambled keys with duplicates, empty range
      tx_idle_pct = 80;
      rx_idle_pct = 13;
      load_table(48, 1'b1, CODE_MAX);
      run_setting(48, 1'b0, 50, 1'b0);
      run_setting(0, 1'b1, 40, 1'b0);

      // no idling: sorted keys spread over the whole code range
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      load_table(48, 1'b0, CODE_MAX);
      run_setting(48, 1'b1, 50, 1'b0);
      run_setting(48, 1'b0, 50, 1'b0);

      wait_idle();
      if (expected_bytes.size() != 0)
         report_mismatch("results missing at end", expected_bytes.size(), 0);

      $display("tb: %0d requests sent, %0d result bytes checked, %0d mismatches",
               requests_sent, results_checked, mismatches);
      $display("tb: covered empty, one-entry and small tables, sorted and scrambled keys");
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
